// ===== hdl/cma_pkg.sv =====
// Shared types and constants for the centered moving average block.
// No dependencies; imported by every module of the block.
`default_nettype none

package cma_pkg;

  // Largest window the history can serve, and the derived sizes
  localparam int MAX_WINDOW    = 32;
  localparam int HALF_MAX      = MAX_WINDOW / 2;
  localparam int HIST_DEPTH    = 2 * HALF_MAX + 1;
  localparam int WIN_W         = 6;
  localparam int WINDOW_RESET  = 3;
  localparam int HALF_W        = $clog2(HALF_MAX + 1);
  localparam int CNT_W         = $clog2(HIST_DEPTH + 1);
  localparam int ADDR_W        = $clog2(HIST_DEPTH);

  // Classification of one accepted sample, handed from front to back end
  typedef struct packed {
    logic              first;    // first sample of a stream
    logic              last;     // final sample of a stream
    logic              emit;     // sample completes one centered result
    logic [HALF_W-1:0] flush_n;  // results still to flush at end of stream
    logic [HALF_W-1:0] half;     // half width in use for this stream
    logic [CNT_W-1:0]  count;    // samples seen in stream, saturated
  } cma_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/cma_front.sv =====
// Front end: holds the window register, tracks stream position and
// classifies each accepted sample. Depends on cma_pkg.
`default_nettype none

module cma_front #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [cma_pkg::WIN_W-1:0]    cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0]       sample_i,
  input  wire logic                         last_i,
  input  wire logic                         full_i,
  output      logic                         push_o,
  output      logic [SAMPLE_BITS-1:0]       push_sample_o,
  output      cma_pkg::cma_ctl_t            push_ctl_o
);

  import cma_pkg::*;

  logic [WIN_W-1:0]  window_q;
  logic [CNT_W-1:0]  rc_q, rc_d, rc_inc;
  logic [HALF_W-1:0] lag_q, lag_d;
  logic [HALF_W-1:0] half_q, half_d;
  logic [WIN_W-1:0]  win_sat;
  logic [HALF_W-1:0] h_new, h_cur, lag_base, lag_after;
  logic [HALF_W:0]   lag_inc;
  logic              first, emit;

  // Stall only when the command queue has no room
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  // Classify the sample against the current stream position
  always_comb begin
    win_sat   = (window_q > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : window_q;
    h_new     = HALF_W'(win_sat >> 1);
    first     = (rc_q == '0);
    h_cur     = first ? h_new : half_q;
    lag_base  = first ? '0 : lag_q;
    lag_inc   = {1'b0, lag_base} + 1'b1;
    emit      = (lag_inc > {1'b0, h_cur});
    lag_after = emit ? h_cur : lag_inc[HALF_W-1:0];
    rc_inc    = (rc_q == CNT_W'(HIST_DEPTH)) ? rc_q : rc_q + 1'b1;

    rc_d   = rc_q;
    lag_d  = lag_q;
    half_d = half_q;
    if (push_o) begin
      half_d = h_cur;
      if (last_i) begin
        rc_d  = '0;
        lag_d = '0;
      end else begin
        rc_d  = rc_inc;
        lag_d = lag_after;
      end
    end

    push_sample_o      = sample_i;
    push_ctl_o.first   = first;
    push_ctl_o.last    = last_i;
    push_ctl_o.emit    = emit;
    push_ctl_o.flush_n = last_i ? lag_after : '0;
    push_ctl_o.half    = h_cur;
    push_ctl_o.count   = rc_inc;
  end

  // Hold window register and stream counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WIN_W'(WINDOW_RESET);
      rc_q     <= '0;
      lag_q    <= '0;
      half_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      rc_q   <= rc_d;
      lag_q  <= lag_d;
      half_q <= half_d;
    end
  end

  // Pending results never exceed the half width
  a_lag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lag_q <= half_q)
    else $error("pending result count exceeds half width");

  // Between streams nothing is pending
  a_idle_no_lag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rc_q == '0) |-> (lag_q == '0))
    else $error("results pending outside a stream");

endmodule

`default_nettype wire

// ===== hdl/cma_queue.sv =====
// Two-entry command queue between the front and back ends.
// Depends on cma_pkg for the command type.
`default_nettype none

module cma_queue #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire logic [SAMPLE_BITS-1:0] push_sample_i,
  input  wire cma_pkg::cma_ctl_t      push_ctl_i,
  output      logic                   full_o,
  input  wire logic                   pop_i,
  output      logic                   empty_o,
  output      logic [SAMPLE_BITS-1:0] pop_sample_o,
  output      cma_pkg::cma_ctl_t      pop_ctl_o
);

  import cma_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int FILL_W = $clog2(QDEPTH + 1);

  logic [SAMPLE_BITS-1:0] smp_mem_q [QDEPTH];
  cma_ctl_t               ctl_mem_q [QDEPTH];
  logic [PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [FILL_W-1:0]      fill_q;
  logic                   do_push, do_pop;

  assign full_o       = (fill_q == FILL_W'(QDEPTH));
  assign empty_o      = (fill_q == '0);
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && !empty_o;
  assign pop_sample_o = smp_mem_q[rd_ptr_q];
  assign pop_ctl_o    = ctl_mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      smp_mem_q[wr_ptr_q] <= push_sample_i;
      ctl_mem_q[wr_ptr_q] <= push_ctl_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cma_back.sv =====
// Back end: sample history, running span sum, bit-serial divider and
// result register. Depends on cma_pkg.
`default_nettype none

module cma_back #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   empty_i,
  output      logic                   pop_o,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire cma_pkg::cma_ctl_t      ctl_i,
  output      logic                   out_valid_o,
  input  wire logic                   out_stall_i,
  output      logic [SAMPLE_BITS-1:0] average_o,
  output      logic                   last_res_o
);

  import cma_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int BIT_W = $clog2(SAMPLE_BITS + 1);
  localparam int PTR_W = ((ADDR_W > CNT_W) ? ADDR_W : CNT_W) + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADD   = 3'd1;
  localparam logic [2:0] ST_PICK  = 3'd2;
  localparam logic [2:0] ST_FSUB  = 3'd3;
  localparam logic [2:0] ST_DINIT = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_SIGN  = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  // Control state
  logic [2:0]             state_q, state_d;
  logic [ADDR_W-1:0]      wp_q, wp_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [CNT_W-1:0]       span_q, span_d;
  logic                   emit_pend_q, emit_pend_d;
  logic [HALF_W-1:0]      flush_q, flush_d;
  logic                   lastres_q, lastres_d;
  logic [BIT_W-1:0]       bit_q, bit_d;

  // Payload
  cma_ctl_t               cur_ctl_q, cur_ctl_d;
  logic [SAMPLE_BITS-1:0] cur_sample_q, cur_sample_d;
  logic [SAMPLE_BITS-1:0] rd_q;
  logic [SUM_W-1:0]       rem_q, rem_d;
  logic [SUM_W-1:0]       dsh_q, dsh_d;
  logic [SAMPLE_BITS-1:0] quo_q, quo_d;
  logic                   neg_q, neg_d;
  logic [SAMPLE_BITS-1:0] avg_q, avg_d;

  logic [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];

  logic [PTR_W-1:0]       wp_ext, span_ext, oldest_ext;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   mem_we, mem_re;
  logic [CNT_W-1:0]       win_cnt, tgt_raw, tgt;
  logic [HALF_W-1:0]      flush_dec;
  logic                   drop, ge;
  logic [SUM_W-1:0]       smp_ext, rd_ext, sum_mag;

  // Address of the oldest sample in the current span
  always_comb begin
    wp_ext     = PTR_W'(wp_q);
    span_ext   = PTR_W'(span_q);
    oldest_ext = (wp_ext >= span_ext) ? (wp_ext - span_ext)
                                      : (wp_ext + PTR_W'(HIST_DEPTH) - span_ext);
    rd_addr    = oldest_ext[ADDR_W-1:0];
  end

  assign pop_o  = (state_q == ST_IDLE) && !empty_i;
  assign mem_we = (state_q == ST_ADD);
  assign mem_re = pop_o || (state_q == ST_PICK);

  // History store: write newest, read oldest of span
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[wp_q] <= cur_sample_q;
    end
    if (mem_re) begin
      rd_q <= hist_mem[rd_addr];
    end
  end

  // Sequencer
  always_comb begin
    win_cnt   = CNT_W'({cur_ctl_q.half, 1'b1});
    drop      = (span_q == win_cnt);
    flush_dec = flush_q - 1'b1;
    tgt_raw   = CNT_W'(flush_dec) + CNT_W'(cur_ctl_q.half) + CNT_W'(1);
    tgt       = (tgt_raw < cur_ctl_q.count) ? tgt_raw : cur_ctl_q.count;
    smp_ext   = {{(SUM_W - SAMPLE_BITS){cur_sample_q[SAMPLE_BITS-1]}}, cur_sample_q};
    rd_ext    = {{(SUM_W - SAMPLE_BITS){rd_q[SAMPLE_BITS-1]}}, rd_q};
    sum_mag   = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
    ge        = (rem_q >= dsh_q);

    state_d      = state_q;
    wp_d         = wp_q;
    sum_d        = sum_q;
    span_d       = span_q;
    emit_pend_d  = emit_pend_q;
    flush_d      = flush_q;
    lastres_d    = lastres_q;
    bit_d        = bit_q;
    cur_ctl_d    = cur_ctl_q;
    cur_sample_d = cur_sample_q;
    rem_d        = rem_q;
    dsh_d        = dsh_q;
    quo_d        = quo_q;
    neg_d        = neg_q;
    avg_d        = avg_q;

    unique case (state_q)
      ST_IDLE: begin
        // Take next command; restart span at stream start
        if (!empty_i) begin
          cur_ctl_d    = ctl_i;
          cur_sample_d = sample_i;
          emit_pend_d  = ctl_i.emit;
          flush_d      = ctl_i.flush_n;
          if (ctl_i.first) begin
            sum_d  = '0;
            span_d = '0;
          end
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        // Add newest sample, drop the one leaving a full window
        sum_d   = sum_q + smp_ext - (drop ? rd_ext : '0);
        span_d  = drop ? span_q : span_q + 1'b1;
        wp_d    = (wp_q == ADDR_W'(HIST_DEPTH - 1)) ? '0 : wp_q + 1'b1;
        state_d = ST_PICK;
      end
      ST_PICK: begin
        // Choose the next result: regular one first, then flush
        if (emit_pend_q) begin
          emit_pend_d = 1'b0;
          lastres_d   = cur_ctl_q.last && (flush_q == '0);
          state_d     = ST_DINIT;
        end else if (flush_q != '0) begin
          flush_d   = flush_dec;
          lastres_d = cur_ctl_q.last && (flush_dec == '0);
          state_d   = (tgt < span_q) ? ST_FSUB : ST_DINIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FSUB: begin
        // Shrink span from its old end
        sum_d   = sum_q - rd_ext;
        span_d  = span_q - 1'b1;
        state_d = ST_DINIT;
      end
      ST_DINIT: begin
        neg_d   = sum_q[SUM_W-1];
        rem_d   = sum_mag;
        dsh_d   = SUM_W'(span_q) << (SAMPLE_BITS - 1);
        quo_d   = '0;
        bit_d   = BIT_W'(SAMPLE_BITS);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // One quotient bit per cycle
        rem_d = ge ? (rem_q - dsh_q) : rem_q;
        quo_d = {quo_q[SAMPLE_BITS-2:0], ge};
        dsh_d = dsh_q >> 1;
        bit_d = bit_q - 1'b1;
        if (bit_q == BIT_W'(1)) begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        avg_d   = neg_q ? (~quo_q + SAMPLE_BITS'(1)) : quo_q;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_PICK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      sum_q       <= '0;
      span_q      <= '0;
      emit_pend_q <= 1'b0;
      flush_q     <= '0;
      lastres_q   <= 1'b0;
      bit_q       <= '0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      sum_q       <= sum_d;
      span_q      <= span_d;
      emit_pend_q <= emit_pend_d;
      flush_q     <= flush_d;
      lastres_q   <= lastres_d;
      bit_q       <= bit_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_ctl_q    <= cur_ctl_d;
    cur_sample_q <= cur_sample_d;
    rem_q        <= rem_d;
    dsh_q        <= dsh_d;
    quo_q        <= quo_d;
    neg_q        <= neg_d;
    avg_q        <= avg_d;
  end

  assign out_valid_o = (state_q == ST_OUT);
  assign average_o   = avg_q;
  assign last_res_o  = lastres_q;

  // Divider never sees an empty span
  a_span_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (span_q != '0))
    else $error("division by empty span");

  // Span stays within the window of the stream
  a_span_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (span_q <= win_cnt))
    else $error("span exceeds window");

  // Final result leaves nothing pending
  a_last_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_res_o) |-> ((flush_q == '0) && !emit_pend_q))
    else $error("final result flagged with results still pending");

endmodule

`default_nettype wire

// ===== hdl/centered_moving_average_top.sv =====
// Top level of the centered moving average: front end, command queue
// and back end. Depends on cma_pkg, cma_front, cma_queue and cma_back.
`default_nettype none

// Centered moving average over a stream of signed samples, with the span
// clipped at both stream ends and the sum divided by the true sample count
// (truncated toward zero). The front end classifies each sample and queues
// it; two samples can wait in the queue while the back end works. In the
// back end a sample is fetched, added to the running sum and dispatched;
// each result it causes then passes the divider and the output register,
// with an extra step when the span shrinks during a flush; a result may
// be held by the output stall. The next sample is taken once all results
// are out. The divider is bit-serial, one quotient bit per cycle. A sample
// ending a stream flushes up to half the window (at most MAX_WINDOW/2) results.
// The window register is read on the first sample of each stream. There is
// no clearing pass after reset.
module centered_moving_average_top #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [cma_pkg::WIN_W-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0]    sample_i,
  input  wire logic                      last_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_stall_i,
  output      logic [SAMPLE_BITS-1:0]    average_o,
  output      logic                      last_res_o
);

  import cma_pkg::*;

  logic                   push, full, pop, empty;
  logic [SAMPLE_BITS-1:0] push_sample, pop_sample;
  cma_ctl_t               push_ctl, pop_ctl;

  cma_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .last_i        (last_i),
    .full_i        (full),
    .push_o        (push),
    .push_sample_o (push_sample),
    .push_ctl_o    (push_ctl)
  );

  cma_queue #(.SAMPLE_BITS(SAMPLE_BITS)) u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .push_sample_i (push_sample),
    .push_ctl_i    (push_ctl),
    .full_o        (full),
    .pop_i         (pop),
    .empty_o       (empty),
    .pop_sample_o  (pop_sample),
    .pop_ctl_o     (pop_ctl)
  );

  cma_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .sample_i    (pop_sample),
    .ctl_i       (pop_ctl),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .average_o   (average_o),
    .last_res_o  (last_res_o)
  );

endmodule

`default_nettype wire
